// ===== rtl/core/emg_gesture_grip_controller_unit_assert.svh =====
// assertion macros for the grip controller, clocked on clk, disabled in reset
`ifndef EMG_GESTURE_GRIP_CONTROLLER_UNIT_ASSERT_SVH
`define EMG_GESTURE_GRIP_CONTROLLER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define EGC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define EGC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define EGC_ASSERT_IMPL(lbl, ante, cons, msg)
`define EGC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/egc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egc_pkg
// shared types and constants of the emg gesture grip controller
// ----------------------------------------------------------------------------
package egc_pkg;

	localparam int FINGER_COUNT = 5;
	localparam int DIV_STEPS    = 8;

	// controller to datapath commands
	typedef struct packed {
		logic load_in;
		logic smooth_en;
		logic smooth_sel;  // 0 flexor, 1 extensor
		logic cls_en;
		logic div_step;
		logic apply;
	} egc_cmd_t;

endpackage

// ===== rtl/core/emg_gesture_grip_controller_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emg_gesture_grip_controller_unit
// two-channel emg gesture classifier driving five finger servos with grip care
// ----------------------------------------------------------------------------
// Each input transaction is one control period and yields one output
// transaction. A period runs from acceptance to a valid result through
// two steps on the shared smoothing multiplier (one per channel), one to
// classify, eight steps of the restoring grip divider and one to update the
// finger and grip state; the next transaction is accepted the cycle after,
// so a new period starts only after the last one is done. The update step
// stalls while an earlier result still waits in the output register.
// The result sits in an output register, so the next period may start while
// it waits. Configuration writes are taken in any cycle but belong to idle
// periods.
module emg_gesture_grip_controller_unit
	import egc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // flexor_sample, extensor_sample, force_level, servo_tick
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // gesture, thumb/index/middle/ring/pinky_angle,
	                               // vibration_level, haptic_events, object_held
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [11:0] cfg_data
);

	egc_cmd_t cmd;

	assign cfg_ready = 1'b1;

	egc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	egc_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.s_tdata   (s_tdata),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tdata   (m_tdata)
	);

endmodule

// ===== rtl/core/egc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egc_ctrl
// sequencer for one control period and the output valid register
// ----------------------------------------------------------------------------
`include "emg_gesture_grip_controller_unit_assert.svh"
module egc_ctrl
	import egc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  logic      m_tready,
	output egc_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SMOOTH_F,
		ST_SMOOTH_E,
		ST_CLASSIFY,
		ST_DIVIDE,
		ST_APPLY
	} state_t;

	state_t      state_q;
	logic [2:0]  cnt_q;
	logic        out_valid_q;
	logic        apply_fire;

	assign s_tready   = (state_q == ST_IDLE);
	assign m_tvalid   = out_valid_q;
	assign apply_fire = (state_q == ST_APPLY) && (!out_valid_q || m_tready);

	always_comb begin
		cmd.load_in    = s_tvalid && (state_q == ST_IDLE);
		cmd.smooth_en  = (state_q == ST_SMOOTH_F) || (state_q == ST_SMOOTH_E);
		cmd.smooth_sel = (state_q == ST_SMOOTH_E);
		cmd.cls_en     = (state_q == ST_CLASSIFY);
		cmd.div_step   = (state_q == ST_DIVIDE);
		cmd.apply      = apply_fire;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready && !apply_fire)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid)
						state_q <= ST_SMOOTH_F;
				end
				ST_SMOOTH_F: state_q <= ST_SMOOTH_E;
				ST_SMOOTH_E: state_q <= ST_CLASSIFY;
				ST_CLASSIFY: begin
					cnt_q   <= '0;
					state_q <= ST_DIVIDE;
				end
				ST_DIVIDE: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'(DIV_STEPS - 1))
						state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					if (apply_fire) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`EGC_ASSERT_NEXT(a_accept_starts, s_tvalid && s_tready, state_q == ST_SMOOTH_F, "accept did not start smoothing")
	`EGC_ASSERT_NEXT(a_apply_valid, apply_fire, out_valid_q, "applied result not presented")
	`EGC_ASSERT_IMPL(a_busy_blocks, state_q != ST_IDLE, !s_tready, "ready while busy")
	`EGC_ASSERT_NEXT(a_div_done, state_q == ST_DIVIDE && cnt_q == 3'(DIV_STEPS - 1), state_q == ST_APPLY, "division step count wrong")

endmodule

// ===== rtl/core/egc_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egc_dpath
// smoothing, classification, grip divider, finger and grip state, result
// ----------------------------------------------------------------------------
module egc_dpath
	import egc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  egc_cmd_t    cmd,
	input  logic [39:0] s_tdata,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [11:0] cfg_data,
	output logic [55:0] m_tdata
);

	typedef enum logic [1:0] {G_OPEN = 2'd0, G_CLOSE = 2'd1, G_POINT = 2'd2} gesture_t;
	typedef enum logic [1:0] {C_KEEP, C_OPEN, C_CLOSE, C_POINT} cls_t;
	typedef enum logic [2:0] {
		R_BASELINE, R_FLEX, R_POINT, R_RELAX, R_CONTACT, R_SLIP, R_OVER, R_OPEN
	} reg_idx_t;

	localparam logic [15:0] ALPHA_Q16      = 16'd6554;
	localparam logic [15:0] ONE_MINUS_Q16  = 16'd58982;
	localparam logic [10:0] GRIP_TOP       = 11'd1800;
	localparam logic [7:0]  GRIP_MIN_ANGLE = 8'd40;
	localparam logic [7:0]  GRIP_MAX_ANGLE = 8'd170;
	localparam logic [7:0]  RESET_ANGLE    = 8'd10;

	function automatic logic [7:0] point_target(input int idx);
		case (idx)
			0:       point_target = 8'd50;
			1:       point_target = 8'd10;
			default: point_target = 8'd170;
		endcase
	endfunction

	function automatic logic [7:0] clamp_close(input logic signed [9:0] v);
		if (v < $signed({2'b00, GRIP_MIN_ANGLE}))
			clamp_close = GRIP_MIN_ANGLE;
		else if (v > $signed({2'b00, GRIP_MAX_ANGLE}))
			clamp_close = GRIP_MAX_ANGLE;
		else
			clamp_close = v[7:0];
	endfunction

	// configuration
	logic [11:0] baseline_q, point_thr_q, relax_thr_q, contact_thr_q, slip_thr_q, over_thr_q;
	logic [10:0] flex_thr_q;
	logic [7:0]  open_angle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			baseline_q    <= 12'd1850;
			flex_thr_q    <= 11'd650;
			point_thr_q   <= 12'd850;
			relax_thr_q   <= 12'd250;
			contact_thr_q <= 12'd180;
			slip_thr_q    <= 12'd150;
			over_thr_q    <= 12'd3200;
			open_angle_q  <= RESET_ANGLE;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				R_BASELINE: baseline_q    <= cfg_data;
				R_FLEX:     flex_thr_q    <= cfg_data[10:0];
				R_POINT:    point_thr_q   <= cfg_data;
				R_RELAX:    relax_thr_q   <= cfg_data;
				R_CONTACT:  contact_thr_q <= cfg_data;
				R_SLIP:     slip_thr_q    <= cfg_data;
				R_OVER:     over_thr_q    <= cfg_data;
				R_OPEN:     open_angle_q  <= cfg_data[7:0];
				default:    baseline_q    <= baseline_q;
			endcase
		end
	end

	// input transaction
	logic [11:0] flex_in_q, ext_in_q, force_in_q;
	logic        tick_in_q;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			flex_in_q  <= s_tdata[11:0];
			ext_in_q   <= s_tdata[23:12];
			force_in_q <= s_tdata[35:24];
			tick_in_q  <= s_tdata[36];
		end
	end

	// shared exponential smoother
	logic [27:0] flex_sm_q, ext_sm_q;
	logic [11:0] raw, rect;
	logic [27:0] s_cur, sm_next;
	logic [24:0] prod_a;
	logic [43:0] prod_b;

	always_comb begin
		raw     = cmd.smooth_sel ? ext_in_q : flex_in_q;
		s_cur   = cmd.smooth_sel ? ext_sm_q : flex_sm_q;
		rect    = (raw >= baseline_q) ? raw - baseline_q : baseline_q - raw;
		prod_a  = 25'(rect) * 25'(ALPHA_Q16);
		prod_b  = 44'(s_cur) * 44'(ONE_MINUS_Q16) + 44'd32768;
		sm_next = 28'(29'(prod_a) + 29'(prod_b[43:16]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flex_sm_q <= '0;
			ext_sm_q  <= '0;
		end else if (cmd.smooth_en) begin
			if (cmd.smooth_sel)
				ext_sm_q <= sm_next;
			else
				flex_sm_q <= sm_next;
		end
	end

	// classification and grip division set-up
	cls_t        cls_q, cls_d;
	logic [11:0] x_int;
	logic [19:0] num, lim;
	logic [10:0] dvs;
	logic        sat;
	logic [19:0] rem_q;
	logic [17:0] dsh_q;
	logic [7:0]  quo_q;
	logic        sat_q;

	always_comb begin
		if (ext_sm_q > {point_thr_q, 16'd0} && ext_sm_q > flex_sm_q)
			cls_d = C_POINT;
		else if (flex_sm_q > {1'b0, flex_thr_q, 16'd0} && flex_sm_q > ext_sm_q)
			cls_d = C_CLOSE;
		else if (flex_sm_q < {relax_thr_q, 16'd0} && ext_sm_q < {relax_thr_q, 16'd0})
			cls_d = C_OPEN;
		else
			cls_d = C_KEEP;
		x_int = flex_sm_q[27:16] - {1'b0, flex_thr_q};
		num   = 20'(x_int * 20'd130);
		dvs   = GRIP_TOP - flex_thr_q;
		lim   = 20'(dvs * 20'd131);
		// quotient at or above 131 clamps to the top anyway
		sat   = (flex_thr_q >= GRIP_TOP) || (num >= lim);
	end

	always_ff @(posedge clk) begin
		if (cmd.cls_en) begin
			cls_q <= cls_d;
			sat_q <= sat;
			rem_q <= num;
			dsh_q <= {dvs, 7'd0};
			quo_q <= '0;
		end else if (cmd.div_step) begin
			if (rem_q >= 20'(dsh_q)) begin
				rem_q <= rem_q - 20'(dsh_q);
				quo_q <= {quo_q[6:0], 1'b1};
			end else begin
				quo_q <= {quo_q[6:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
		end
	end

	// grip state and result
	gesture_t    gest_q, gest_new;
	logic [7:0]  pos_q [FINGER_COUNT];
	logic [7:0]  tgt_q [FINGER_COUNT];
	logic [7:0]  pos_new [FINGER_COUNT];
	logic [7:0]  tgt_cls [FINGER_COUNT];
	logic [7:0]  tgt_slip [FINGER_COUNT];
	logic [7:0]  tgt_new [FINGER_COUNT];
	logic        held_q, held_cls, held_new;
	logic [11:0] prev_force_q;
	logic [7:0]  grip;
	logic        is_close, contact, slip, over, point_entered;
	logic [18:0] vib_prod, vib_rem;
	logic [6:0]  vib_est, vib_q, vib;

	always_comb begin
		grip     = sat_q ? GRIP_MAX_ANGLE : GRIP_MIN_ANGLE + quo_q;
		gest_new = gest_q;
		held_cls = held_q;
		case (cls_q)
			C_POINT: gest_new = G_POINT;
			C_CLOSE: gest_new = G_CLOSE;
			C_OPEN: begin
				gest_new = G_OPEN;
				held_cls = 1'b0;
			end
			default: gest_new = gest_q;
		endcase
		for (int i = 0; i < FINGER_COUNT; i++) begin
			case (cls_q)
				C_POINT: tgt_cls[i] = point_target(i);
				C_CLOSE: tgt_cls[i] = grip;
				C_OPEN:  tgt_cls[i] = open_angle_q;
				default: tgt_cls[i] = tgt_q[i];
			endcase
			if (tick_in_q && pos_q[i] < tgt_cls[i])
				pos_new[i] = pos_q[i] + 8'd1;
			else if (tick_in_q && pos_q[i] > tgt_cls[i])
				pos_new[i] = pos_q[i] - 8'd1;
			else
				pos_new[i] = pos_q[i];
		end
		is_close = (gest_new == G_CLOSE);
		contact  = is_close && !held_cls && (force_in_q > contact_thr_q);
		held_new = held_cls || contact;
		slip     = is_close && held_new && (prev_force_q > force_in_q)
			&& ((prev_force_q - force_in_q) > slip_thr_q);
		over     = is_close && (force_in_q > over_thr_q);
		for (int i = 0; i < FINGER_COUNT; i++) begin
			tgt_slip[i] = slip ? clamp_close(10'(tgt_cls[i]) + 10'sd4) : tgt_cls[i];
			tgt_new[i]  = over ? clamp_close(10'(tgt_slip[i]) - 10'sd2) : tgt_slip[i];
		end
		point_entered = (gest_new == G_POINT) && (gest_q != G_POINT);
		// force * 127 / 4095: estimate by the shift, then one correction
		vib_prod = {force_in_q, 7'd0} - 19'(force_in_q);
		vib_est  = vib_prod[18:12];
		vib_rem  = vib_prod - {vib_est, 12'd0} + 19'(vib_est);
		vib_q    = (vib_rem >= 19'd4095) ? vib_est + 7'd1 : vib_est;
		vib      = (vib_q < 7'd10) ? 7'd0 : vib_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gest_q       <= G_OPEN;
			held_q       <= 1'b0;
			prev_force_q <= '0;
			for (int i = 0; i < FINGER_COUNT; i++) begin
				pos_q[i] <= RESET_ANGLE;
				tgt_q[i] <= RESET_ANGLE;
			end
		end else if (cmd.apply) begin
			gest_q <= gest_new;
			held_q <= held_new;
			if (is_close)
				prev_force_q <= force_in_q;
			for (int i = 0; i < FINGER_COUNT; i++) begin
				pos_q[i] <= pos_new[i];
				tgt_q[i] <= tgt_new[i];
			end
		end
	end

	logic [55:0] out_q;

	always_ff @(posedge clk) begin
		if (cmd.apply)
			out_q <= {2'b00, held_new, point_entered, over, slip, contact, vib,
				pos_new[4], pos_new[3], pos_new[2], pos_new[1], pos_new[0], gest_new};
	end

	assign m_tdata = out_q;

endmodule
